>>> rtl/core/psp_pkg.sv
// shared constants, codes and types of the phase shift pi controller
package psp_pkg;

  // pwm timing and fixed point format
  localparam int PERIOD_COUNT = 4096;
  localparam int FRAC_BITS    = 16;

  localparam logic [15:0] FULL_CMP = 16'(PERIOD_COUNT);
  localparam logic [15:0] HALF_CMP = 16'(PERIOD_COUNT / 2);

  // 0.001 in q0.32 and 0.1 rounded up in the working format
  localparam int MILLI_Q32 = 4294967;
  localparam int TENTH_Q   = ((1 << FRAC_BITS) + 9) / 10;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // machine states
  localparam logic [2:0] ST_POWER_ON = 3'd0;
  localparam logic [2:0] ST_TRIP     = 3'd1;
  localparam logic [2:0] ST_READY    = 3'd2;
  localparam logic [2:0] ST_INIT_RUN = 3'd3;
  localparam logic [2:0] ST_RUN      = 3'd4;
  localparam logic [2:0] ST_GO_STOP  = 3'd5;

  // state commands
  localparam logic [2:0] CMD_KEEP       = 3'd0;
  localparam logic [2:0] CMD_POWER_ON   = 3'd1;
  localparam logic [2:0] CMD_READY      = 3'd2;
  localparam logic [2:0] CMD_INIT_RUN   = 3'd3;
  localparam logic [2:0] CMD_RUN        = 3'd4;
  localparam logic [2:0] CMD_GO_STOP    = 3'd5;
  localparam logic [2:0] CMD_CLEAR_TRIP = 3'd6;

  // control modes
  localparam logic [3:0] MODE_TEST_PHASE = 4'd2;
  localparam logic [3:0] MODE_PI         = 4'd3;
  localparam logic [3:0] MODE_DIRECT     = 4'd8;
  localparam logic [3:0] MODE_PULSE_TEST = 4'd9;

  // register indexes
  localparam logic [2:0] REG_CONTROL_MODE     = 3'd0;
  localparam logic [2:0] REG_PROP_GAIN        = 3'd1;
  localparam logic [2:0] REG_INTEG_GAIN_TS    = 3'd2;
  localparam logic [2:0] REG_INTEG_LIMIT      = 3'd3;
  localparam logic [2:0] REG_PHASE_RATIO_MAX  = 3'd4;
  localparam logic [2:0] REG_INIT_PHASE_RATIO = 3'd5;
  localparam logic [2:0] REG_TEST_PHASE_RATIO = 3'd6;
  localparam logic [2:0] REG_PULSE_LIMIT      = 3'd7;

  localparam logic [30:0] INTEG_LIMIT_RST = 31'd65536;
  localparam logic [17:0] RATIO_MAX_RST   = 18'd65536;

  typedef struct packed {
    logic [3:0]  control_mode;
    logic [30:0] prop_gain;
    logic [30:0] integ_gain_ts;
    logic [30:0] integ_limit;
    logic [17:0] phase_ratio_max;
    logic [17:0] init_phase_ratio;
    logic [17:0] test_phase_ratio;
    logic [15:0] pulse_limit;
  } cfg_t;

  typedef struct packed {
    logic        ext_trip_n;
    logic [7:0]  fault_code;
    logic [2:0]  state_command;
    logic [31:0] reference;
    logic [31:0] measured_current;
  } item_t;

  typedef struct packed {
    logic [15:0] duty_compare;
    logic [15:0] phase_count;
    logic        gate_enable;
    logic [2:0]  machine_state;
    logic [7:0]  trip_code;
  } res_t;

endpackage

>>> rtl/core/phase_shift_pwm_pi_controller.sv
// top level: config registers, input capture and output register of the controller
//
// One input transfer per pwm period tick; each gives exactly one result transfer.
// Input channel (in_valid/in_ready) carries the trip line, fault code, state
// command, reference and measured current. Output channel (out_valid/out_ready)
// carries duty compare, phase count, gate enable, machine state and trip code.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
// and writes one register per transfer; write it only while the block is idle.
// From an input transfer the core steps through decide to done for steps without
// a phase computation; a ratio turned into a phase count adds a multiply and a
// result step, and a pi loop step first runs current, error, gain and ratio steps.
// in_ready stays low from an input transfer until its result moves into the output
// register. The pi step runs six products through the one 33x25 multiplier in turn.
// A result waiting in the output register does not block the next input; if
// the receiver stalls longer, the finished result waits inside the core and
// in_ready stays low. Reset clears the machine to power-on with no trip, a zero
// integral, full-period compare and loads the register defaults.
module phase_shift_pwm_pi_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               ext_trip_n,
  input  logic [7:0]         fault_code,
  input  logic [2:0]         state_command,
  input  logic signed [31:0] reference,
  input  logic signed [31:0] measured_current,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        duty_compare,
  output logic [15:0]        phase_count,
  output logic               gate_enable,
  output logic [2:0]         machine_state,
  output logic [7:0]         trip_code,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import psp_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res;
  logic  core_idle;
  logic  core_done;
  logic  res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_mode     <= '0;
      cfg.prop_gain        <= '0;
      cfg.integ_gain_ts    <= '0;
      cfg.integ_limit      <= INTEG_LIMIT_RST;
      cfg.phase_ratio_max  <= RATIO_MAX_RST;
      cfg.init_phase_ratio <= '0;
      cfg.test_phase_ratio <= '0;
      cfg.pulse_limit      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CONTROL_MODE:     cfg.control_mode     <= cfg_data[3:0];
        REG_PROP_GAIN:        cfg.prop_gain        <= cfg_data[30:0];
        REG_INTEG_GAIN_TS:    cfg.integ_gain_ts    <= cfg_data[30:0];
        REG_INTEG_LIMIT:      cfg.integ_limit      <= cfg_data[30:0];
        REG_PHASE_RATIO_MAX:  cfg.phase_ratio_max  <= cfg_data[17:0];
        REG_INIT_PHASE_RATIO: cfg.init_phase_ratio <= cfg_data[17:0];
        REG_TEST_PHASE_RATIO: cfg.test_phase_ratio <= cfg_data[17:0];
        REG_PULSE_LIMIT:      cfg.pulse_limit      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign item.ext_trip_n       = ext_trip_n;
  assign item.fault_code       = fault_code;
  assign item.state_command    = state_command;
  assign item.reference        = reference;
  assign item.measured_current = measured_current;

  assign in_ready  = core_idle;
  assign res_ready = !out_valid || out_ready;

  psp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (in_valid && in_ready),
    .item      (item),
    .idle      (core_idle),
    .done      (core_done),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, loaded when the core finishes and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_done && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done && res_ready) begin
      duty_compare  <= res.duty_compare;
      phase_count   <= res.phase_count;
      gate_enable   <= res.gate_enable;
      machine_state <= res.machine_state;
      trip_code     <= res.trip_code;
    end
  end

  // one item in the core at a time
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while core busy");

  // a latched trip always shows the trip state with gates off
  a_trip_gates_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (trip_code != 8'd0) |-> (machine_state == ST_TRIP) && !gate_enable)
    else $error("trip latched without trip state or with gates on");

  a_compare_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_compare == FULL_CMP) || (duty_compare == HALF_CMP))
    else $error("duty compare is neither full nor half period");

endmodule

>>> rtl/core/psp_mul.sv
// shared signed multiplier with registered product
module psp_mul (
  input  logic                                clk,
  input  logic signed [psp_pkg::MUL_A_W-1:0]  a,
  input  logic signed [psp_pkg::MUL_B_W-1:0]  b,
  output logic signed [psp_pkg::MUL_P_W-1:0]  p
);
  import psp_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

>>> rtl/core/psp_core.sv
// supervisor state machine and pi sequencer around the shared multiplier
module psp_core (
  input  logic           clk,
  input  logic           rst,
  input  psp_pkg::cfg_t  cfg,
  input  logic           start,
  input  psp_pkg::item_t item,
  output logic           idle,
  output logic           done,
  input  logic           res_ready,
  output psp_pkg::res_t  res
);
  import psp_pkg::*;

  localparam logic [3:0] SQ_IDLE    = 4'd0;
  localparam logic [3:0] SQ_DECIDE  = 4'd1;
  localparam logic [3:0] SQ_CUR     = 4'd2;
  localparam logic [3:0] SQ_ERR     = 4'd3;
  localparam logic [3:0] SQ_KI_LO   = 4'd4;
  localparam logic [3:0] SQ_KI_HI   = 4'd5;
  localparam logic [3:0] SQ_KI_ACC  = 4'd6;
  localparam logic [3:0] SQ_INTEG   = 4'd7;
  localparam logic [3:0] SQ_KP_ACC  = 4'd8;
  localparam logic [3:0] SQ_RATIO   = 4'd9;
  localparam logic [3:0] SQ_PH_MUL  = 4'd10;
  localparam logic [3:0] SQ_PH_RES  = 4'd11;
  localparam logic [3:0] SQ_DONE    = 4'd12;

  localparam int ERR_W  = 34;
  localparam int ERR_LO = 17;
  localparam int ERR_HI = ERR_W - ERR_LO;
  localparam int ACC_W  = 66;
  localparam int SH_W   = ACC_W - FRAC_BITS;
  localparam int SUM_W  = SH_W + 1;
  localparam int RAT_W  = 33;
  localparam int SCL_W  = MUL_P_W - 32;
  localparam int PQ_LSB = FRAC_BITS + 1;

  logic [3:0]               seq, seq_next;
  item_t                    item_r, item_next;
  logic [2:0]               mode_state, mode_state_next;
  logic [7:0]               trip_latch, trip_latch_next;
  logic                     ports_set, ports_set_next;
  logic [15:0]              pulse_cnt, pulse_cnt_next;
  logic                     gate_on, gate_on_next;
  logic [15:0]              compare_r, compare_next;
  logic [15:0]              phase_r, phase_next;
  logic signed [31:0]       integral, integral_next;
  logic signed [RAT_W-1:0]  ratio, ratio_next;
  logic signed [ERR_W-1:0]  err, err_next;
  logic signed [ACC_W-1:0]  acc, acc_next;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] p;

  // command and trip evaluation
  logic [2:0] ms_cmd;
  logic [7:0] tl_cmd;
  logic [7:0] tl_ext;
  logic [7:0] tl_final;
  logic       tripped;

  // arithmetic helpers
  logic signed [SCL_W-1:0]  scaled;
  logic signed [ERR_W-1:0]  err_calc;
  logic signed [ACC_W-1:0]  p_ext;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [SH_W-1:0]   acc_sh;
  logic signed [SUM_W-1:0]  integ_sum;
  logic signed [SUM_W-1:0]  ratio_sum;
  logic signed [SUM_W-1:0]  lim_pos;
  logic signed [SUM_W-1:0]  lim_neg;
  logic signed [SUM_W-1:0]  max_ext;
  logic signed [SUM_W-1:0]  integ_ext;
  logic signed [31:0]       integ_clamped;
  logic signed [RAT_W-1:0]  ratio_clamped;
  logic [15:0]              phase_sat;
  logic                     ratio_pos;
  logic                     below_tenth;

  psp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  assign scaled    = $signed(p[MUL_P_W-1:32]);
  assign err_calc  = {{(ERR_W-32){item_r.reference[31]}}, item_r.reference}
                   - {{(ERR_W-SCL_W){scaled[SCL_W-1]}}, scaled};
  assign p_ext     = {{(ACC_W-MUL_P_W){p[MUL_P_W-1]}}, p};
  assign acc_sum   = acc + (p_ext <<< ERR_LO);
  assign acc_sh    = $signed(acc[ACC_W-1:FRAC_BITS]);
  assign integ_ext = {{(SUM_W-32){integral[31]}}, integral};
  assign integ_sum = {acc_sh[SH_W-1], acc_sh} + integ_ext;
  assign ratio_sum = integ_sum;
  assign lim_pos   = $signed({{(SUM_W-31){1'b0}}, cfg.integ_limit});
  assign lim_neg   = -lim_pos;
  assign max_ext   = $signed({{(SUM_W-18){1'b0}}, cfg.phase_ratio_max});
  assign ratio_pos = !ratio[RAT_W-1] && (ratio != '0);
  assign below_tenth = $signed(item_r.reference) < $signed(32'(TENTH_Q));

  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_clamped = 32'(lim_pos);
    end else if (integ_sum < lim_neg) begin
      integ_clamped = 32'(lim_neg);
    end else begin
      integ_clamped = 32'(integ_sum);
    end
  end

  always_comb begin
    if (ratio_sum < 0) begin
      ratio_clamped = '0;
    end else if (ratio_sum > max_ext) begin
      ratio_clamped = RAT_W'(max_ext);
    end else begin
      ratio_clamped = RAT_W'(ratio_sum);
    end
  end

  // product is positive here, floor shift then saturate to 16 bits
  always_comb begin
    if (p[MUL_P_W-1:PQ_LSB+16] != '0) begin
      phase_sat = 16'hFFFF;
    end else begin
      phase_sat = p[PQ_LSB+15:PQ_LSB];
    end
  end

  always_comb begin
    ms_cmd = mode_state;
    tl_cmd = trip_latch;
    unique case (item_r.state_command) inside
      CMD_POWER_ON: ms_cmd = ST_POWER_ON;
      CMD_READY, CMD_INIT_RUN, CMD_RUN, CMD_GO_STOP: ms_cmd = item_r.state_command;
      CMD_CLEAR_TRIP: begin
        tl_cmd = '0;
        ms_cmd = ST_POWER_ON;
      end
      default: ;
    endcase
    tl_ext   = item_r.ext_trip_n ? tl_cmd : 8'hFF;
    tl_final = (tl_ext == '0) ? item_r.fault_code : tl_ext;
    tripped  = tl_final != '0;
  end

  // multiplier operand selection per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (seq)
      SQ_CUR: begin
        mul_a = {item_r.measured_current[31], item_r.measured_current};
        mul_b = MUL_B_W'(MILLI_Q32);
      end
      SQ_KI_LO: begin
        mul_a = {2'b00, cfg.integ_gain_ts};
        mul_b = {{(MUL_B_W-ERR_LO){1'b0}}, err[ERR_LO-1:0]};
      end
      SQ_KI_HI: begin
        mul_a = {2'b00, cfg.integ_gain_ts};
        mul_b = {{(MUL_B_W-ERR_HI){err[ERR_W-1]}}, err[ERR_W-1:ERR_LO]};
      end
      SQ_KI_ACC: begin
        mul_a = {2'b00, cfg.prop_gain};
        mul_b = {{(MUL_B_W-ERR_LO){1'b0}}, err[ERR_LO-1:0]};
      end
      SQ_INTEG: begin
        mul_a = {2'b00, cfg.prop_gain};
        mul_b = {{(MUL_B_W-ERR_HI){err[ERR_W-1]}}, err[ERR_W-1:ERR_LO]};
      end
      SQ_PH_MUL: begin
        mul_a = ratio;
        mul_b = MUL_B_W'(PERIOD_COUNT);
      end
      default: ;
    endcase
  end

  always_comb begin
    seq_next        = seq;
    item_next       = item_r;
    mode_state_next = mode_state;
    trip_latch_next = trip_latch;
    ports_set_next  = ports_set;
    pulse_cnt_next  = pulse_cnt;
    gate_on_next    = gate_on;
    compare_next    = compare_r;
    phase_next      = phase_r;
    integral_next   = integral;
    ratio_next      = ratio;
    err_next        = err;
    acc_next        = acc;
    unique case (seq)
      SQ_IDLE: begin
        if (start) begin
          item_next = item;
          seq_next  = SQ_DECIDE;
        end
      end
      SQ_DECIDE: begin
        trip_latch_next = tl_final;
        mode_state_next = ms_cmd;
        seq_next        = SQ_DONE;
        if (tripped) begin
          mode_state_next = ST_TRIP;
          gate_on_next    = 1'b0;
        end else begin
          unique case (ms_cmd)
            ST_READY: begin
              compare_next   = HALF_CMP;
              ports_set_next = 1'b0;
              phase_next     = '0;
              pulse_cnt_next = '0;
            end
            ST_INIT_RUN: begin
              compare_next = HALF_CMP;
              ratio_next   = {{(RAT_W-18){1'b0}}, cfg.init_phase_ratio};
              if (!ports_set) begin
                gate_on_next   = 1'b1;
                ports_set_next = 1'b1;
                seq_next       = SQ_PH_MUL;
              end else if (cfg.control_mode == MODE_PULSE_TEST) begin
                if (pulse_cnt < cfg.pulse_limit) begin
                  pulse_cnt_next = pulse_cnt + 16'd1;
                  seq_next       = SQ_PH_MUL;
                end else begin
                  mode_state_next = ST_READY;
                  gate_on_next    = 1'b0;
                end
              end else begin
                seq_next = SQ_PH_MUL;
              end
            end
            ST_RUN: begin
              compare_next = HALF_CMP;
              unique case (cfg.control_mode)
                MODE_PI: seq_next = SQ_CUR;
                MODE_DIRECT: begin
                  ratio_next = {item_r.reference[31], item_r.reference};
                  seq_next   = SQ_PH_MUL;
                end
                MODE_TEST_PHASE: begin
                  ratio_next = {{(RAT_W-18){1'b0}}, cfg.test_phase_ratio};
                  seq_next   = SQ_PH_MUL;
                end
                default: phase_next = '0;
              endcase
            end
            ST_GO_STOP: begin
              compare_next = HALF_CMP;
              if (below_tenth) begin
                phase_next      = '0;
                ports_set_next  = 1'b0;
                gate_on_next    = 1'b0;
                mode_state_next = ST_READY;
              end else begin
                ratio_next = {item_r.reference[31], item_r.reference};
                seq_next   = SQ_PH_MUL;
              end
            end
            default: begin
              compare_next   = FULL_CMP;
              ports_set_next = 1'b0;
              phase_next     = '0;
              gate_on_next   = 1'b0;
            end
          endcase
        end
      end
      SQ_CUR:    seq_next = SQ_ERR;
      SQ_ERR: begin
        err_next = err_calc;
        seq_next = SQ_KI_LO;
      end
      SQ_KI_LO:  seq_next = SQ_KI_HI;
      SQ_KI_HI: begin
        acc_next = p_ext;
        seq_next = SQ_KI_ACC;
      end
      SQ_KI_ACC: begin
        acc_next = acc_sum;
        seq_next = SQ_INTEG;
      end
      SQ_INTEG: begin
        integral_next = integ_clamped;
        acc_next      = p_ext;
        seq_next      = SQ_KP_ACC;
      end
      SQ_KP_ACC: begin
        acc_next = acc_sum;
        seq_next = SQ_RATIO;
      end
      SQ_RATIO: begin
        ratio_next = ratio_clamped;
        seq_next   = SQ_PH_MUL;
      end
      SQ_PH_MUL: seq_next = SQ_PH_RES;
      SQ_PH_RES: begin
        phase_next = ratio_pos ? phase_sat : '0;
        seq_next   = SQ_DONE;
      end
      SQ_DONE: begin
        if (res_ready) begin
          seq_next = SQ_IDLE;
        end
      end
      default: seq_next = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq        <= SQ_IDLE;
      mode_state <= ST_POWER_ON;
      trip_latch <= '0;
      ports_set  <= 1'b0;
      pulse_cnt  <= '0;
      gate_on    <= 1'b0;
      compare_r  <= FULL_CMP;
      phase_r    <= '0;
      integral   <= '0;
    end else begin
      seq        <= seq_next;
      mode_state <= mode_state_next;
      trip_latch <= trip_latch_next;
      ports_set  <= ports_set_next;
      pulse_cnt  <= pulse_cnt_next;
      gate_on    <= gate_on_next;
      compare_r  <= compare_next;
      phase_r    <= phase_next;
      integral   <= integral_next;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_next;
    ratio  <= ratio_next;
    err    <= err_next;
    acc    <= acc_next;
  end

  assign idle = seq == SQ_IDLE;
  assign done = seq == SQ_DONE;

  assign res.duty_compare  = compare_r;
  assign res.phase_count   = phase_r;
  assign res.gate_enable   = gate_on;
  assign res.machine_state = mode_state;
  assign res.trip_code     = trip_latch;

endmodule
